// ===== rtl/core/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg - shared types and constants of the RC channel calibrator
// Widths, operation and register codes, entry layout, divider handshake
// structs and the controller state type.
// ----------------------------------------------------------------------------
package rcc_pkg;

  // channel store depth and its address width
  localparam int NUM_CHANNELS = 12;
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // field widths
  localparam int VW      = 12;  // sample / range value
  localparam int CHW     = 4;   // channel index
  localparam int FNW     = 2;   // operation code
  localparam int NPW     = 5;   // switch position count
  localparam int POSW    = 4;   // switch position
  localparam int FRACW   = 16;  // throttle neutral fraction
  localparam int MASKW   = 12;  // reverse mask
  localparam int CFG_IW  = 3;   // config register index
  localparam int CFG_DW  = 16;  // config write data

  // reverse mask padded to cover every channel code
  localparam int MASK_EXT = 1 << CHW;

  // switch scaling: full scale, quotient bits, position count limit
  localparam int SMAGW    = 9;
  localparam int S_FULL   = 256;
  localparam int QBITS    = 10;
  localparam int QCW      = $clog2(QBITS + 1);
  localparam int NPOS_MAX = 16;

  // operation codes
  typedef enum logic [FNW-1:0] {
    FN_LOAD   = 2'd0,
    FN_CAL    = 2'd1,
    FN_FINISH = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  // config register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_CAL_MODE = 3'd0,
    CFG_REV_MASK = 3'd1,
    CFG_THR_CH   = 3'd2,
    CFG_FLT_CH   = 3'd3,
    CFG_NEU_FRAC = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             cal_mode;
    logic [MASKW-1:0] rev_mask;
    logic [CHW-1:0]   thr_ch;
    logic [CHW-1:0]   flt_ch;
    logic [FRACW-1:0] neu_frac;
  } cfg_t;

  // one channel entry as stored in the entry RAM
  typedef struct packed {
    logic [VW-1:0] mn;
    logic [VW-1:0] mx;
    logic [VW-1:0] nt;
  } ent_t;

  // switch divider request / response
  typedef struct packed {
    logic          start;
    logic [VW-1:0] num;
    logic [VW-1:0] den;
    logic          neg;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [SMAGW-1:0] mag;
  } div_rsp_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } st_t;

endpackage

// ===== rtl/core/rcc_ifs.sv =====
// ----------------------------------------------------------------------------
// rcc_ifs - valid/ready channel interfaces of the RC channel calibrator
// Input beat: one channel operation. Output beat: the resulting entry.
// ----------------------------------------------------------------------------
interface rcc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcc_pkg::FNW-1:0]   func;
  logic [rcc_pkg::CHW-1:0]   channel;
  logic [rcc_pkg::VW-1:0]    value;
  logic [rcc_pkg::VW-1:0]    load_min;
  logic [rcc_pkg::VW-1:0]    load_max;
  logic [rcc_pkg::NPW-1:0]   switch_positions;

  modport source (output valid, func, channel, value, load_min, load_max,
                  switch_positions, input ready);
  modport sink   (input valid, func, channel, value, load_min, load_max,
                  switch_positions, output ready);
endinterface

interface rcc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rcc_pkg::VW-1:0]    min_out;
  logic [rcc_pkg::VW-1:0]    max_out;
  logic [rcc_pkg::VW-1:0]    neutral_out;
  logic [rcc_pkg::POSW-1:0]  position;
  logic                      bad_channel;

  modport source (output valid, min_out, max_out, neutral_out, position,
                  bad_channel, input ready);
  modport sink   (input valid, min_out, max_out, neutral_out, position,
                  bad_channel, output ready);
endinterface

// ===== rtl/core/rcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rcc_cfg_regs - configuration register file
// Write-only registers, decoded by index; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module rcc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rcc_pkg::CFG_DW-1:0]  cfg_wdata,
  output rcc_pkg::cfg_t               cfg
);

  rcc_pkg::cfg_t cfg_r, cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (rcc_pkg::cfg_idx_t'(cfg_index))
        rcc_pkg::CFG_CAL_MODE: cfg_nxt.cal_mode = cfg_wdata[0];
        rcc_pkg::CFG_REV_MASK: cfg_nxt.rev_mask = cfg_wdata[rcc_pkg::MASKW-1:0];
        rcc_pkg::CFG_THR_CH:   cfg_nxt.thr_ch   = cfg_wdata[rcc_pkg::CHW-1:0];
        rcc_pkg::CFG_FLT_CH:   cfg_nxt.flt_ch   = cfg_wdata[rcc_pkg::CHW-1:0];
        rcc_pkg::CFG_NEU_FRAC: cfg_nxt.neu_frac = cfg_wdata[rcc_pkg::FRACW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_mode <= 1'b0;
      cfg_r.rev_mask <= '0;
      cfg_r.thr_ch   <= rcc_pkg::CHW'(0);
      cfg_r.flt_ch   <= rcc_pkg::CHW'(4);
      cfg_r.neu_frac <= rcc_pkg::FRACW'(1311);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/rcc_entry_ram.sv =====
// ----------------------------------------------------------------------------
// rcc_entry_ram - channel entry store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcc_entry_ram #(
  parameter int DEPTH = 12,
  parameter int AW    = 4,
  parameter int DW    = 36
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rcc_switch_div.sv =====
// ----------------------------------------------------------------------------
// rcc_switch_div - switch scaling divider
// Computes min(|num| * 256 / |den|, 256) by restoring division, one quotient
// bit per cycle. Quotients of 1024 and up are caught before the loop.
// ----------------------------------------------------------------------------
module rcc_switch_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rcc_pkg::div_req_t  req,
  output rcc_pkg::div_rsp_t  rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [rcc_pkg::QCW-1:0]    cnt_r, cnt_nxt;
  logic [rcc_pkg::VW-1:0]     rem_r, rem_nxt;
  logic [rcc_pkg::VW-1:0]     den_r, den_nxt;
  logic [rcc_pkg::QBITS-1:0]  sh_r, sh_nxt;
  logic [rcc_pkg::QBITS-1:0]  q_r, q_nxt;
  logic                       neg_r, neg_nxt;
  logic [rcc_pkg::SMAGW-1:0]  mag_r, mag_nxt;
  logic [rcc_pkg::VW+1:0]     trial;
  logic                       sat;
  logic [rcc_pkg::QBITS-1:0]  q_fin;

  // quotient >= 1024 when |num| >= 4 * |den|
  assign sat   = {2'b00, req.num} >= {req.den, 2'b00};
  assign trial = {1'b0, rem_r, sh_r[rcc_pkg::QBITS-1]} - {2'b00, den_r};
  assign q_fin = {q_r[rcc_pkg::QBITS-2:0], ~trial[rcc_pkg::VW+1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    if (req.start) begin
      neg_nxt = req.neg;
      den_nxt = req.den;
      if (req.den == '0) begin
        mag_nxt  = '0;
        done_nxt = 1'b1;
      end else if (sat) begin
        mag_nxt  = rcc_pkg::SMAGW'(rcc_pkg::S_FULL);
        done_nxt = 1'b1;
      end else begin
        // numerator is num followed by eight zero bits
        rem_nxt  = {2'b00, req.num[rcc_pkg::VW-1:2]};
        sh_nxt   = {req.num[1:0], 8'h00};
        q_nxt    = '0;
        cnt_nxt  = rcc_pkg::QCW'(rcc_pkg::QBITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = trial[rcc_pkg::VW+1] ? {rem_r[rcc_pkg::VW-2:0], sh_r[rcc_pkg::QBITS-1]}
                                     : trial[rcc_pkg::VW-1:0];
      sh_nxt  = {sh_r[rcc_pkg::QBITS-2:0], 1'b0};
      q_nxt   = q_fin;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rcc_pkg::QCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        mag_nxt  = (q_fin > rcc_pkg::QBITS'(rcc_pkg::S_FULL))
                   ? rcc_pkg::SMAGW'(rcc_pkg::S_FULL) : q_fin[rcc_pkg::SMAGW-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.mag  = mag_r;

endmodule

// ===== rtl/core/rc_channel_calibrator.sv =====
// ----------------------------------------------------------------------------
// rc_channel_calibrator - RC channel range and neutral calibration
// Keeps min, max and neutral per channel in a RAM and serves load,
// calibrate, finish and switch-position operations, one beat at a time.
// ----------------------------------------------------------------------------
// One input beat is handled at a time. Load, calibrate and finish beats go
// from acceptance to the output beat through RAM read, widen, multiply and
// write back; after the multiply a switch query runs the 10-step serial divider,
// whose loop is skipped when the quotient saturates or the range side is
// zero. A new beat is accepted as soon as the controller is idle, even
// while the previous result still waits on the output register; an item
// only stalls at its final step if that register is still full. Out-of-range
// channels return zeros with bad_channel set and leave the store untouched.
// Entries must be loaded or calibrated before they are queried; the store
// is not cleared at reset.
module rc_channel_calibrator (
  input  logic                        clk,
  input  logic                        rst_n,
  rcc_in_if.sink                      in_ch,
  rcc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [rcc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rcc_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int VW = rcc_pkg::VW;

  rcc_pkg::cfg_t      cfg;
  rcc_pkg::st_t       st_r, st_nxt;
  rcc_pkg::ent_t      ram_rdata, ram_wdata;
  rcc_pkg::div_req_t  div_req;
  rcc_pkg::div_rsp_t  div_rsp;

  // controller decodes
  logic in_accept, ram_re, ram_we, div_start, out_load, out_free, bad_in;

  // beat registers
  rcc_pkg::func_t            func_r;
  logic [rcc_pkg::CHW-1:0]   ch_r;
  logic [VW-1:0]             value_r, lmin_r, lmax_r;
  logic [rcc_pkg::NPW-1:0]   npos_r;
  logic                      bad_r;

  // working entry and product
  logic [VW-1:0]             mn_r, mx_r, nt_r;
  logic signed [29:0]        prod_r;

  // output register
  logic                      out_valid_r;
  logic [VW-1:0]             min_out_r, max_out_r, nt_out_r;
  logic [rcc_pkg::POSW-1:0]  pos_out_r;
  logic                      bad_out_r;

  // combinational datapath
  logic [rcc_pkg::MASK_EXT-1:0] rev_ext;
  logic                      rev;
  logic [VW-1:0]             w_mn, w_mx;
  logic signed [VW:0]        span, diff, dsel;
  logic                      up_side;
  logic signed [13:0]        thr_sum;
  logic [VW-1:0]             thr_nt, mid_nt, new_nt, fin_mn, fin_mx;
  logic [VW:0]               mid_sum;
  logic [rcc_pkg::NPW-1:0]   n_eff;
  logic [rcc_pkg::QBITS-1:0] s_off;
  logic [14:0]               p_prod;
  logic [5:0]                p_raw;
  logic [rcc_pkg::POSW-1:0]  pos;

  // configuration registers
  rcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // channel entry store
  rcc_entry_ram #(
    .DEPTH (rcc_pkg::NUM_CHANNELS),
    .AW    (rcc_pkg::CH_AW),
    .DW    ($bits(rcc_pkg::ent_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_r[rcc_pkg::CH_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_ch.channel[rcc_pkg::CH_AW-1:0]),
    .rdata (ram_rdata)
  );

  // switch scaling divider
  rcc_switch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign bad_in    = {1'b0, in_ch.channel} >= (rcc_pkg::CHW + 1)'(rcc_pkg::NUM_CHANNELS);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rcc_pkg::ST_IDLE: begin
        if (in_accept) st_nxt = bad_in ? rcc_pkg::ST_FIN : rcc_pkg::ST_READ;
      end
      rcc_pkg::ST_READ: st_nxt = rcc_pkg::ST_MUL;
      rcc_pkg::ST_MUL: begin
        st_nxt = (func_r == rcc_pkg::FN_QUERY) ? rcc_pkg::ST_DIV : rcc_pkg::ST_FIN;
      end
      rcc_pkg::ST_DIV: begin
        if (div_rsp.done) st_nxt = rcc_pkg::ST_FIN;
      end
      rcc_pkg::ST_FIN: begin
        if (out_free) st_nxt = rcc_pkg::ST_IDLE;
      end
      default: st_nxt = rcc_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (st_r)
      rcc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_re      = in_ch.valid && !bad_in;
      end
      rcc_pkg::ST_MUL: div_start = (func_r == rcc_pkg::FN_QUERY);
      rcc_pkg::ST_FIN: begin
        out_load = out_free;
        ram_we   = out_free && !bad_r && (func_r != rcc_pkg::FN_QUERY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= rcc_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= rcc_pkg::func_t'(in_ch.func);
      ch_r    <= in_ch.channel;
      value_r <= in_ch.value;
      lmin_r  <= in_ch.load_min;
      lmax_r  <= in_ch.load_max;
      npos_r  <= in_ch.switch_positions;
      bad_r   <= bad_in;
    end
  end

  // widen the stored range toward the sample
  assign rev_ext = rcc_pkg::MASK_EXT'(cfg.rev_mask);
  assign rev     = rev_ext[ch_r];

  always_comb begin
    w_mn = ram_rdata.mn;
    w_mx = ram_rdata.mx;
    if (func_r == rcc_pkg::FN_CAL) begin
      if (!cfg.cal_mode) begin
        if (ram_rdata.mn <= ram_rdata.mx) begin
          if (ram_rdata.mn > value_r) w_mn = value_r;
          if (ram_rdata.mx < value_r) w_mx = value_r;
        end else begin
          if (ram_rdata.mx > value_r) w_mx = value_r;
          if (ram_rdata.mn < value_r) w_mn = value_r;
        end
      end else begin
        if ((!rev && ram_rdata.mn > value_r) || (rev && ram_rdata.mn < value_r)) w_mn = value_r;
        if ((!rev && ram_rdata.mx < value_r) || (rev && ram_rdata.mx > value_r)) w_mx = value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == rcc_pkg::ST_READ) begin
      mn_r <= w_mn;
      mx_r <= w_mx;
      nt_r <= ram_rdata.nt;
    end
  end

  // throttle product: (max - min) * fraction
  assign span = $signed({1'b0, mx_r}) - $signed({1'b0, mn_r});

  always_ff @(posedge clk) begin
    if (st_r == rcc_pkg::ST_MUL) begin
      prod_r <= span * $signed({1'b0, cfg.neu_frac});
    end
  end

  // switch divider operands: pick the half-range on the sample's side
  assign diff    = $signed({1'b0, value_r}) - $signed({1'b0, nt_r});
  assign up_side = ((mx_r > mn_r) && (value_r >= nt_r)) ||
                   ((mn_r > mx_r) && (value_r <= nt_r));
  assign dsel    = up_side ? ($signed({1'b0, mx_r}) - $signed({1'b0, nt_r}))
                           : ($signed({1'b0, nt_r}) - $signed({1'b0, mn_r}));

  always_comb begin
    div_req.start = div_start;
    div_req.num   = diff[VW] ? VW'(-diff) : diff[VW-1:0];
    div_req.den   = dsel[VW] ? VW'(-dsel) : dsel[VW-1:0];
    div_req.neg   = diff[VW] ^ dsel[VW];
  end

  // neutral candidates: floor of the product, and the midpoint
  assign thr_sum = $signed({2'b00, mn_r}) + prod_r[29:16];
  assign thr_nt  = thr_sum[VW-1:0];
  assign mid_sum = {1'b0, mn_r} + {1'b0, mx_r};
  assign mid_nt  = mid_sum[VW:1];

  // new entry for the operation
  always_comb begin
    fin_mn = mn_r;
    fin_mx = mx_r;
    new_nt = nt_r;
    case (func_r)
      rcc_pkg::FN_LOAD: begin
        fin_mn = lmin_r;
        fin_mx = lmax_r;
        new_nt = value_r;
      end
      rcc_pkg::FN_CAL: begin
        if (cfg.cal_mode)             new_nt = value_r;
        else if (ch_r == cfg.thr_ch)  new_nt = thr_nt;
        else                          new_nt = mid_nt;
      end
      rcc_pkg::FN_FINISH: begin
        if (ch_r == cfg.thr_ch)       new_nt = thr_nt;
        else if (ch_r == cfg.flt_ch)  new_nt = mid_nt;
        else                          new_nt = value_r;
      end
      default: ;
    endcase
  end

  assign ram_wdata.mn = fin_mn;
  assign ram_wdata.mx = fin_mx;
  assign ram_wdata.nt = new_nt;

  // switch position from the scaled value s: ((s + 256) * n) >> 9
  assign n_eff  = (npos_r > rcc_pkg::NPW'(rcc_pkg::NPOS_MAX))
                  ? rcc_pkg::NPW'(rcc_pkg::NPOS_MAX) : npos_r;
  assign s_off  = div_rsp.neg
                  ? rcc_pkg::QBITS'(rcc_pkg::S_FULL) - rcc_pkg::QBITS'(div_rsp.mag)
                  : rcc_pkg::QBITS'(rcc_pkg::S_FULL) + rcc_pkg::QBITS'(div_rsp.mag);
  assign p_prod = 15'(s_off) * 15'(n_eff);
  assign p_raw  = p_prod[14:9];

  always_comb begin
    if (n_eff == '0)                pos = '0;
    else if (p_raw >= 6'(n_eff))    pos = rcc_pkg::POSW'(n_eff - 1'b1);
    else                            pos = p_raw[rcc_pkg::POSW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      min_out_r <= bad_r ? '0 : fin_mn;
      max_out_r <= bad_r ? '0 : fin_mx;
      nt_out_r  <= bad_r ? '0 : new_nt;
      pos_out_r <= (!bad_r && func_r == rcc_pkg::FN_QUERY) ? pos : '0;
      bad_out_r <= bad_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_out     = min_out_r;
  assign out_ch.max_out     = max_out_r;
  assign out_ch.neutral_out = nt_out_r;
  assign out_ch.position    = pos_out_r;
  assign out_ch.bad_channel = bad_out_r;

endmodule
